/* rtl/i2cmbe_pkg.sv */
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared types, codes and helpers for the byte engine.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

   localparam int WAIT_WIDTH = 16;
   localparam int HALF_WIDTH = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [HALF_WIDTH-1:0] HALF_RESET = HALF_WIDTH'(5);
   localparam logic [7:0] MSB_MASK = 8'h80;

   localparam logic [2:0] OP_TICK = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_STOP = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_READ_ACK = 3'd4;
   localparam logic [2:0] OP_READ_NACK = 3'd5;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_START,
      CMD_STOP,
      CMD_WRITE,
      CMD_READ
   } cmd_type;

   typedef enum logic [12:0] {
      PH_IDLE  = 13'b0000000000001,
      PH_ST_A  = 13'b0000000000010,
      PH_ST_B  = 13'b0000000000100,
      PH_SP_A  = 13'b0000000001000,
      PH_SP_B  = 13'b0000000010000,
      PH_W_LO  = 13'b0000000100000,
      PH_W_HI  = 13'b0000001000000,
      PH_W_REL = 13'b0000010000000,
      PH_W_ACK = 13'b0000100000000,
      PH_R_LO  = 13'b0001000000000,
      PH_R_HI  = 13'b0010000000000,
      PH_A_LO  = 13'b0100000000000,
      PH_A_HI  = 13'b1000000000000
   } phase_type;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] tx_byte;
      logic sda_in;
   } req_payload_type;

   typedef struct packed {
      logic scl_level;
      logic sda_level;
      logic sda_drive;
      logic busy_res;
      logic done_res;
      logic [7:0] rx_byte;
      logic ack_received;
   } rsp_payload_type;

   typedef struct packed {
      cmd_type cmd;
      logic reply_nack;
      logic [7:0] tx_byte;
      logic sda_in;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [WAIT_WIDTH-1:0] period_eff(input logic [HALF_WIDTH-1:0] half);
      logic [32:0] hx;
      logic [32:0] wmax;
      begin
         hx = 33'(half);
         wmax = (33'd1 << WAIT_WIDTH) - 33'd1;
         if (hx == 33'd0) begin
            hx = 33'd1;
         end
         if (hx > wmax) begin
            hx = wmax;
         end
         return hx[WAIT_WIDTH-1:0];
      end
   endfunction

endpackage

/* rtl/i2cmbe_if.sv */
// ----------------------------------------------------------------------------
// I2C master byte engine channels
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface i2cmbe_req_if import i2cmbe_pkg::*; ();
   logic valid;
   logic ready;
   req_payload_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

interface i2cmbe_rsp_if import i2cmbe_pkg::*; ();
   logic valid;
   logic ready;
   rsp_payload_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

/* rtl/i2cmbe_front.sv */
// ----------------------------------------------------------------------------
// I2C master byte engine front end
// Accepts request items and decodes the op field into a command.
// ----------------------------------------------------------------------------
module i2cmbe_front import i2cmbe_pkg::*; (
   input  logic clock,
   input  logic reset,
   i2cmbe_req_if.sink req_chan,
   input  q_status_type q_stat,
   output logic push_valid,
   output entry_type push_entry
);

   logic valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic take;
   logic pushed;

   assign pushed = valid_ff && !q_stat.full;
   assign req_chan.ready = !valid_ff || !q_stat.full;
   assign take = req_chan.valid && req_chan.ready;
   assign push_valid = valid_ff;
   assign push_entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (pushed) begin
         valid_in = 1'b0;
      end
      if (take) begin
         valid_in = 1'b1;
         entry_in.tx_byte = req_chan.data.tx_byte;
         entry_in.sda_in = req_chan.data.sda_in;
         entry_in.reply_nack = 1'b0;
         case (req_chan.data.op)
            OP_START: begin
               entry_in.cmd = CMD_START;
            end
            OP_STOP: begin
               entry_in.cmd = CMD_STOP;
            end
            OP_WRITE: begin
               entry_in.cmd = CMD_WRITE;
            end
            OP_READ_ACK: begin
               entry_in.cmd = CMD_READ;
            end
            OP_READ_NACK: begin
               entry_in.cmd = CMD_READ;
               entry_in.reply_nack = 1'b1;
            end
            default: begin
               entry_in.cmd = CMD_NONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

endmodule

/* rtl/i2cmbe_queue.sv */
// ----------------------------------------------------------------------------
// I2C master byte engine command queue
// Short register queue between the front end and the bus sequencer.
// ----------------------------------------------------------------------------
module i2cmbe_queue import i2cmbe_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic push_valid,
   input  entry_type push_entry,
   input  logic pop,
   output entry_type head,
   output q_status_type q_stat
);

   entry_type slot_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign q_stat.full = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign do_push = push_valid && !q_stat.full;
   assign do_pop = pop && !q_stat.empty;
   assign head = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/i2cmbe_back.sv */
// ----------------------------------------------------------------------------
// I2C master byte engine bus sequencer
// Runs the bus phases one item per cycle unless stalled, registering responses.
// ----------------------------------------------------------------------------
module i2cmbe_back import i2cmbe_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic [HALF_WIDTH-1:0] half_period,
   input  entry_type head,
   input  q_status_type q_stat,
   output logic pop,
   i2cmbe_rsp_if.source rsp_chan
);

   phase_type phase_ff, phase_in;
   logic [3:0] bit_ff, bit_in;
   logic [WAIT_WIDTH-1:0] wait_ff, wait_in;
   logic [7:0] shift_ff, shift_in;
   logic scl_ff, scl_in;
   logic sda_ff, sda_in;
   logic drv_ff, drv_in;
   logic [7:0] last_rx_ff, last_rx_in;
   logic ack_ff, ack_in;
   logic nack_ff, nack_in;
   logic done;
   logic [WAIT_WIDTH-1:0] wait_dec;
   logic [WAIT_WIDTH-1:0] period;
   logic [3:0] bit_inc;
   logic [7:0] rd_shift;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   assign pop = !q_stat.empty && (!rsp_valid_ff || rsp_chan.ready);
   assign period = period_eff(half_period);
   assign wait_dec = wait_ff - 1'b1;
   assign bit_inc = bit_ff + 1'b1;
   assign rd_shift = {shift_ff[6:0], head.sda_in};
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data = rsp_ff;

   always_comb begin
      phase_in = phase_ff;
      bit_in = bit_ff;
      wait_in = wait_ff;
      shift_in = shift_ff;
      scl_in = scl_ff;
      sda_in = sda_ff;
      drv_in = drv_ff;
      last_rx_in = last_rx_ff;
      ack_in = ack_ff;
      nack_in = nack_ff;
      done = 1'b0;
      if (phase_ff == PH_IDLE) begin
         case (head.cmd)
            CMD_START: begin
               drv_in = 1'b1;
               sda_in = 1'b1;
               scl_in = 1'b1;
               phase_in = PH_ST_A;
               wait_in = period;
            end
            CMD_STOP: begin
               drv_in = 1'b1;
               sda_in = 1'b0;
               scl_in = 1'b1;
               phase_in = PH_SP_A;
               wait_in = period;
            end
            CMD_WRITE: begin
               shift_in = head.tx_byte;
               bit_in = '0;
               drv_in = 1'b1;
               scl_in = 1'b0;
               sda_in = |(head.tx_byte & MSB_MASK);
               phase_in = PH_W_LO;
               wait_in = period;
            end
            CMD_READ: begin
               nack_in = head.reply_nack;
               shift_in = '0;
               bit_in = '0;
               drv_in = 1'b0;
               scl_in = 1'b0;
               phase_in = PH_R_LO;
               wait_in = period;
            end
            default: begin
            end
         endcase
      end else begin
         wait_in = wait_dec;
         if (wait_dec == '0) begin
            wait_in = period;
            case (phase_ff)
               PH_ST_A: begin
                  sda_in = 1'b0;
                  phase_in = PH_ST_B;
               end
               PH_ST_B: begin
                  scl_in = 1'b0;
                  done = 1'b1;
               end
               PH_SP_A: begin
                  sda_in = 1'b1;
                  phase_in = PH_SP_B;
               end
               PH_SP_B: begin
                  done = 1'b1;
               end
               PH_W_LO: begin
                  scl_in = 1'b1;
                  phase_in = PH_W_HI;
               end
               PH_W_HI: begin
                  bit_in = bit_inc;
                  scl_in = 1'b0;
                  if (bit_inc < 4'd8) begin
                     shift_in = {shift_ff[6:0], 1'b0};
                     sda_in = shift_ff[6];
                     phase_in = PH_W_LO;
                  end else begin
                     sda_in = 1'b1;
                     phase_in = PH_W_REL;
                  end
               end
               PH_W_REL: begin
                  drv_in = 1'b0;
                  scl_in = 1'b1;
                  phase_in = PH_W_ACK;
               end
               PH_W_ACK: begin
                  ack_in = !head.sda_in;
                  scl_in = 1'b0;
                  done = 1'b1;
               end
               PH_R_LO: begin
                  scl_in = 1'b1;
                  phase_in = PH_R_HI;
               end
               PH_R_HI: begin
                  shift_in = rd_shift;
                  bit_in = bit_inc;
                  scl_in = 1'b0;
                  if (bit_inc < 4'd8) begin
                     phase_in = PH_R_LO;
                  end else begin
                     last_rx_in = rd_shift;
                     drv_in = 1'b1;
                     sda_in = nack_ff;
                     phase_in = PH_A_LO;
                  end
               end
               PH_A_LO: begin
                  scl_in = 1'b1;
                  phase_in = PH_A_HI;
               end
               PH_A_HI: begin
                  scl_in = 1'b0;
                  sda_in = !nack_ff;
                  done = 1'b1;
               end
               default: begin
                  done = 1'b1;
               end
            endcase
            if (done) begin
               phase_in = PH_IDLE;
               wait_in = '0;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (pop) begin
         rsp_valid_in = 1'b1;
         rsp_in.scl_level = scl_in;
         rsp_in.sda_level = sda_in;
         rsp_in.sda_drive = drv_in;
         rsp_in.busy_res = (phase_in != PH_IDLE);
         rsp_in.done_res = done;
         rsp_in.rx_byte = last_rx_in;
         rsp_in.ack_received = ack_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bit_ff <= '0;
         wait_ff <= '0;
         shift_ff <= '0;
         scl_ff <= 1'b1;
         sda_ff <= 1'b1;
         drv_ff <= 1'b1;
         last_rx_ff <= '0;
         ack_ff <= 1'b0;
         nack_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff <= phase_in;
            bit_ff <= bit_in;
            wait_ff <= wait_in;
            shift_ff <= shift_in;
            scl_ff <= scl_in;
            sda_ff <= sda_in;
            drv_ff <= drv_in;
            last_rx_ff <= last_rx_in;
            ack_ff <= ack_in;
            nack_ff <= nack_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

endmodule

/* rtl/i2c_master_byte_engine.sv */
// ----------------------------------------------------------------------------
// I2C master byte engine
// Tick-driven I2C master that runs start, stop, byte write and byte read.
// ----------------------------------------------------------------------------
//   channel   direction   handshake     carries
//   req_chan  in          valid/ready   op, tx_byte, sda_in (one tick)
//   rsp_chan  out         valid/ready   line levels, busy, done, rx_byte, ack
//   csr       in          write enable  half_period_ticks
//
// One request item is taken per cycle unless stalled. Its response item passes
// the front register, the queue and the output register before it is offered.
// The per-tick bus state update in the sequencer sets the one-item-per-cycle rate.
// A stalled response side fills the two-entry queue and the front register,
// then holds req_chan.ready low.
// Reset is synchronous and returns the lines to SCL high, SDA high and driven.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine import i2cmbe_pkg::*; (
   input  logic clock,
   input  logic reset,
   i2cmbe_req_if.sink req_chan,
   i2cmbe_rsp_if.source rsp_chan,
   input  logic csr_wr_en,
   input  logic [HALF_WIDTH-1:0] csr_wr_data
);

   logic [HALF_WIDTH-1:0] half_ff;
   logic push_valid;
   entry_type push_entry;
   entry_type head;
   q_status_type q_stat;
   logic pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= HALF_RESET;
      end else if (csr_wr_en) begin
         half_ff <= csr_wr_data;
      end
   end

   i2cmbe_front u_front (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .q_stat(q_stat),
      .push_valid(push_valid),
      .push_entry(push_entry)
   );

   i2cmbe_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_entry(push_entry),
      .pop(pop),
      .head(head),
      .q_stat(q_stat)
   );

   i2cmbe_back u_back (
      .clock(clock),
      .reset(reset),
      .half_period(half_ff),
      .head(head),
      .q_stat(q_stat),
      .pop(pop),
      .rsp_chan(rsp_chan)
   );

`ifndef SYNTHESIS
   a_queue_state: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("Queue reports full and empty at once.");

   a_pop_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_chan.valid)
      else $error("A popped item did not produce a response item.");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.data.done_res |-> !rsp_chan.data.busy_res)
      else $error("A completing item still reports busy.");
`endif

endmodule
